// ===== rtl/core/isv_pkg.sv =====
// Package for the interpolated schedule value core: formats, config layout, pipeline types.
package isv_pkg;

  // Fixed-point formats
  localparam int VALUE_FRAC_BITS    = 16;
  localparam int PROGRESS_FRAC_BITS = 16;
  localparam int VALUE_W            = 32;
  localparam int PROG_W             = PROGRESS_FRAC_BITS + 1;

  // 1.0 in progress format
  localparam logic [PROG_W-1:0] PROG_ONE = {1'b1, {PROGRESS_FRAC_BITS{1'b0}}};

  // 0.1 in value format, rounded
  localparam int                 TENTH_INT = ((1 << VALUE_FRAC_BITS) + 5) / 10;
  localparam logic [VALUE_W-1:0] TENTH     = VALUE_W'(TENTH_INT);

  // Divider: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (PROGRESS_FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

  // Front, divider, three ease stages, two blend stages
  localparam int LATENCY = DIV_STAGES + 6;

  // Product widths
  localparam int MUL_W  = 2 * PROG_W;
  localparam int PROD_W = VALUE_W + 1 + PROG_W + 1;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (VALUE_W > PROG_W) ? VALUE_W : PROG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_OFFSET     = 3'd0,
    REG_END_OFFSET       = 3'd1,
    REG_PRE_OFFSET_VALUE = 3'd2,
    REG_START_VALUE      = 3'd3,
    REG_END_VALUE        = 3'd4,
    REG_EVALUATION_VALUE = 3'd5,
    REG_CURVE_MODE       = 3'd6,
    REG_TIME_SOURCE      = 3'd7
  } isv_reg_e;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_QUAD   = 2'd1,
    CURVE_CUBIC  = 2'd2
  } isv_curve_e;

  typedef struct packed {
    logic [PROG_W-1:0]  start_offset;
    logic [PROG_W-1:0]  end_offset;
    logic [VALUE_W-1:0] pre_offset_value;
    logic [VALUE_W-1:0] start_value;
    logic [VALUE_W-1:0] end_value;
    logic [VALUE_W-1:0] evaluation_value;
    logic [1:0]         curve_mode;
    logic               time_source;
  } isv_cfg_t;

  // Per-item flags that pick the final output source
  typedef struct packed {
    logic eval;
    logic pre;
  } isv_tag_t;

  // Divider stage payload
  typedef struct packed {
    isv_tag_t                      tag;
    logic                          byp;
    logic [PROG_W-1:0]             byp_p;
    logic [PROG_W-1:0]             rem;
    logic [PROG_W-1:0]             den;
    logic [PROGRESS_FRAC_BITS-1:0] quo;
  } isv_div_t;

  // Progress-format value travelling with its flags
  typedef struct packed {
    isv_tag_t          tag;
    logic [PROG_W-1:0] p;
  } isv_p_t;

endpackage

// ===== rtl/core/isv_front.sv =====
// Front stage: progress select, offset check and divider setup.
module isv_front import isv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  isv_cfg_t          cfg_i,
  input  logic [PROG_W-1:0] experiment_progress_i,
  input  logic [PROG_W-1:0] episode_progress_i,
  input  logic              is_evaluation_i,
  output logic              valid_o,
  output isv_div_t          div_o
);

  logic              valid_q;
  isv_div_t          div_d, div_q;
  logic [PROG_W-1:0] prog;
  logic [PROG_W-1:0] diff;
  logic [PROG_W-1:0] den;
  logic              off_en;

  // Offset handling and saturation cases
  always_comb begin
    prog   = cfg_i.time_source ? episode_progress_i : experiment_progress_i;
    off_en = (cfg_i.start_offset != '0);
    diff   = prog - cfg_i.start_offset;
    den    = cfg_i.end_offset - cfg_i.start_offset;

    div_d.tag.eval = is_evaluation_i;
    div_d.tag.pre  = off_en && (prog < cfg_i.start_offset);
    div_d.rem      = diff;
    div_d.den      = den;
    div_d.quo      = '0;
    if (!off_en) begin
      div_d.byp   = 1'b1;
      div_d.byp_p = (prog > PROG_ONE) ? PROG_ONE : prog;
    end else begin
      // empty span or ratio at or above 1.0 saturates
      div_d.byp   = (cfg_i.end_offset <= cfg_i.start_offset) || (diff >= den);
      div_d.byp_p = PROG_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ===== rtl/core/isv_divider.sv =====
// Pipelined restoring divider: a few quotient bits per stage.
module isv_divider import isv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  isv_div_t div_i,
  output logic     valid_o,
  output isv_p_t   p_o
);

  logic     vld [DIV_STAGES+1];
  isv_div_t st  [DIV_STAGES+1];

  assign vld[0] = valid_i;
  assign st[0]  = div_i;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    isv_div_t nxt;

    // Shift, compare, subtract for each quotient bit of this stage
    always_comb begin
      logic [PROG_W:0] sh;
      sh  = '0;
      nxt = st[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (s * DIV_STEPS + k < PROGRESS_FRAC_BITS) begin
          sh = {nxt.rem, 1'b0};
          if (sh >= {1'b0, nxt.den}) begin
            nxt.rem = PROG_W'(sh - {1'b0, nxt.den});
            nxt.quo = {nxt.quo[PROGRESS_FRAC_BITS-2:0], 1'b1};
          end else begin
            nxt.rem = sh[PROG_W-1:0];
            nxt.quo = {nxt.quo[PROGRESS_FRAC_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      st[s+1] <= nxt;
    end
  end

  // Quotient, or the bypass value for saturated and offset-free items
  assign valid_o = vld[DIV_STAGES];
  assign p_o.tag = st[DIV_STAGES].tag;
  assign p_o.p   = st[DIV_STAGES].byp ? st[DIV_STAGES].byp_p
                                      : {1'b0, st[DIV_STAGES].quo};

endmodule

// ===== rtl/core/isv_ease.sv =====
// Ease curve: weight w from progress p in three multiplier stages.
module isv_ease import isv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] curve_mode_i,
  input  logic       valid_i,
  input  isv_p_t     p_i,
  output logic       valid_o,
  output isv_p_t     w_o
);

  // stage 1: q = 1 - p, q*q
  logic              v1_q;
  isv_tag_t          tag1_q;
  logic [PROG_W-1:0] p1_q, q1_q;
  logic [MUL_W-1:0]  qq1_q;
  logic [PROG_W-1:0] q_d;
  // stage 2: q2, q2*q
  logic              v2_q;
  isv_tag_t          tag2_q;
  logic [PROG_W-1:0] p2_q, q2_q;
  logic [MUL_W-1:0]  q2q_q;
  logic [PROG_W-1:0] q2_d;
  // stage 3: weight
  logic              v3_q;
  isv_p_t            w3_q;
  logic [PROG_W-1:0] qk;
  logic [MUL_W-1:0]  m;
  logic              ease_on;

  assign q_d     = PROG_ONE - p_i.p;
  assign q2_d    = qq1_q[PROGRESS_FRAC_BITS +: PROG_W];
  assign ease_on = (curve_mode_i == CURVE_QUAD) || (curve_mode_i == CURVE_CUBIC);

  always_comb begin
    qk = (curve_mode_i == CURVE_CUBIC) ? q2q_q[PROGRESS_FRAC_BITS +: PROG_W] : q2_q;
    m  = MUL_W'(PROG_ONE - qk) * MUL_W'(p2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q   <= p_i.tag;
    p1_q     <= p_i.p;
    q1_q     <= q_d;
    qq1_q    <= MUL_W'(q_d) * MUL_W'(q_d);
    tag2_q   <= tag1_q;
    p2_q     <= p1_q;
    q2_q     <= q2_d;
    q2q_q    <= MUL_W'(q2_d) * MUL_W'(q1_q);
    w3_q.tag <= tag2_q;
    w3_q.p   <= ease_on ? m[PROGRESS_FRAC_BITS +: PROG_W] : p2_q;
  end

  assign valid_o = v3_q;
  assign w_o     = w3_q;

endmodule

// ===== rtl/core/isv_blend.sv =====
// Blend: start + floor((end - start) * w), then output source select.
module isv_blend import isv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isv_cfg_t           cfg_i,
  input  logic               valid_i,
  input  isv_p_t             w_i,
  output logic               valid_o,
  output logic [VALUE_W-1:0] value_o
);

  logic signed [VALUE_W:0]   diff_q;
  logic                      v1_q;
  isv_tag_t                  tag1_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  sh;
  logic signed [PROD_W:0]    sum;
  logic [VALUE_W-1:0]        ramp;
  logic [VALUE_W-1:0]        res_d;
  logic                      v2_q;
  logic [VALUE_W-1:0]        res_q;
  logic [PROD_W-VALUE_W+1:0] hi;

  // Span tracks the config registers
  always_ff @(posedge clk_i) begin
    diff_q <= $signed({cfg_i.end_value[VALUE_W-1], cfg_i.end_value})
            - $signed({cfg_i.start_value[VALUE_W-1], cfg_i.start_value});
  end

  assign prod_d = $signed({{(PROG_W+1){diff_q[VALUE_W]}}, diff_q})
                * $signed({{(VALUE_W+2){1'b0}}, w_i.p});

  // Floor shift, add start, clamp to the value range
  always_comb begin
    sh   = prod_q >>> PROGRESS_FRAC_BITS;
    sum  = $signed({{(PROD_W-VALUE_W+1){cfg_i.start_value[VALUE_W-1]}}, cfg_i.start_value})
         + $signed({sh[PROD_W-1], sh});
    hi   = sum[PROD_W:VALUE_W-1];
    if ((&hi) || !(|hi)) begin
      ramp = sum[VALUE_W-1:0];
    end else if (sum[PROD_W]) begin
      ramp = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      ramp = {1'b0, {(VALUE_W-1){1'b1}}};
    end
    priority if (tag1_q.eval) begin
      res_d = cfg_i.evaluation_value;
    end else if (tag1_q.pre) begin
      res_d = cfg_i.pre_offset_value;
    end else begin
      res_d = ramp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= w_i.tag;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign valid_o = v2_q;
  assign value_o = res_q;

endmodule

// ===== rtl/core/interpolated_schedule_value_core.sv =====
// Top level of the interpolated schedule value core: config registers and pipeline.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------------
//  item in  | start_i, busy_o       | experiment_progress_i, episode_progress_i,
//           |                       | is_evaluation_i
//  result   | valid_o (strobe)      | scheduled_value_o
//  config   | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
//  One item per cycle. Each item passes through one front stage, DIV_STAGES
//  divider stages at four quotient bits each, three ease multiplier stages and
//  two blend stages.
//  Reset clears the valid bits and loads the config defaults.
//  busy_o stays low; the pipeline never stalls and results are never held.
module interpolated_schedule_value_core import isv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [PROG_W-1:0]     experiment_progress_i,
  input  logic [PROG_W-1:0]     episode_progress_i,
  input  logic                  is_evaluation_i,
  output logic                  valid_o,
  output logic [VALUE_W-1:0]    scheduled_value_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  isv_cfg_t cfg_q;
  logic     accept;
  logic     fr_valid;
  isv_div_t fr_div;
  logic     dv_valid;
  isv_p_t   dv_p;
  logic     es_valid;
  isv_p_t   es_w;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_offset     <= '0;
      cfg_q.end_offset       <= PROG_ONE;
      cfg_q.pre_offset_value <= TENTH;
      cfg_q.start_value      <= TENTH;
      cfg_q.end_value        <= '0;
      cfg_q.evaluation_value <= '0;
      cfg_q.curve_mode       <= CURVE_LINEAR;
      cfg_q.time_source      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (isv_reg_e'(cfg_idx_i))
        REG_START_OFFSET:     cfg_q.start_offset     <= cfg_wdata_i[PROG_W-1:0];
        REG_END_OFFSET:       cfg_q.end_offset       <= cfg_wdata_i[PROG_W-1:0];
        REG_PRE_OFFSET_VALUE: cfg_q.pre_offset_value <= cfg_wdata_i[VALUE_W-1:0];
        REG_START_VALUE:      cfg_q.start_value      <= cfg_wdata_i[VALUE_W-1:0];
        REG_END_VALUE:        cfg_q.end_value        <= cfg_wdata_i[VALUE_W-1:0];
        REG_EVALUATION_VALUE: cfg_q.evaluation_value <= cfg_wdata_i[VALUE_W-1:0];
        REG_CURVE_MODE:       cfg_q.curve_mode       <= cfg_wdata_i[1:0];
        REG_TIME_SOURCE:      cfg_q.time_source      <= cfg_wdata_i[0];
      endcase
    end
  end

  isv_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .accept_i              (accept),
    .cfg_i                 (cfg_q),
    .experiment_progress_i (experiment_progress_i),
    .episode_progress_i    (episode_progress_i),
    .is_evaluation_i       (is_evaluation_i),
    .valid_o               (fr_valid),
    .div_o                 (fr_div)
  );

  isv_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .div_i   (fr_div),
    .valid_o (dv_valid),
    .p_o     (dv_p)
  );

  isv_ease u_ease (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .curve_mode_i (cfg_q.curve_mode),
    .valid_i      (dv_valid),
    .p_i          (dv_p),
    .valid_o      (es_valid),
    .w_o          (es_w)
  );

  isv_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (es_valid),
    .w_i     (es_w),
    .valid_o (valid_o),
    .value_o (scheduled_value_o)
  );

endmodule

// ===== rtl/core/isv_checker.sv =====
// Port-level checker for the interpolated schedule value core, with its bind.
module isv_checker import isv_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               is_evaluation_i,
  input logic               valid_o,
  input logic [VALUE_W-1:0] scheduled_value_o,
  input logic               cfg_we_i
);

  logic acc;
  assign acc = start_i && !busy_o && rst_ni;

  // The pipeline never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o raised");

  // Every accepted item gives a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LATENCY valid_o)
    else $error("result missing after accepted item");

  // No result without a matching item accepted earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(acc, LATENCY))
    else $error("result without item");

  // Back-to-back evaluation items with quiet config give the same value
  a_eval_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(valid_o) && $past(is_evaluation_i, LATENCY)
     && $past(is_evaluation_i, LATENCY + 1) && !$past(cfg_we_i, 1)
     && !$past(cfg_we_i, 2)) |-> $stable(scheduled_value_o))
    else $error("evaluation value changed without a config write");

endmodule

bind interpolated_schedule_value_core isv_checker u_isv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .is_evaluation_i   (is_evaluation_i),
  .valid_o           (valid_o),
  .scheduled_value_o (scheduled_value_o),
  .cfg_we_i          (cfg_we_i)
);

// ===== tb/sv/interpolated_schedule_value_core_tb.sv =====
// Self-checking testbench for the interpolated schedule value core.
`timescale 1ns / 100ps

module interpolated_schedule_value_core_tb;
  import isv_pkg::*;

  // Curve code with no ease, handled as a linear ramp
  localparam logic [1:0] CURVE_SPARE = 2'd3;
  localparam longint unsigned P_ONE = PROG_ONE;
  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;
  localparam int VAL_LO = 32'h8000_0000;
  localparam int VAL_HI = 32'h7fff_ffff;

  typedef struct packed {
    logic [PROG_W-1:0] exp_p;
    logic [PROG_W-1:0] epi_p;
    logic              eval;
  } sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [PROG_W-1:0]     experiment_progress_i = '0;
  logic [PROG_W-1:0]     episode_progress_i = '0;
  logic                  is_evaluation_i = 1'b0;
  logic                  valid_o;
  logic [VALUE_W-1:0]    scheduled_value_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Mirror of the config registers, reset values
  logic [PROG_W-1:0] start_off = '0;
  logic [PROG_W-1:0] end_off = PROG_ONE;
  int                pre_val = TENTH;
  int                start_val = TENTH;
  int                end_val = 0;
  int                eval_val = 0;
  logic [1:0]        curve = CURVE_LINEAR;
  logic              use_episode = 1'b0;

  sample_t            samples_to_send[$];
  logic [VALUE_W-1:0] values_due[$];
  sample_t            next_sample;
  logic [VALUE_W-1:0] want_value;
  logic               send_now;
  logic               gaps_on = 1'b1;
  int                 gap_left = 0;
  int                 err_count = 0;

  interpolated_schedule_value_core dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .experiment_progress_i(experiment_progress_i),
    .episode_progress_i   (episode_progress_i),
    .is_evaluation_i      (is_evaluation_i),
    .valid_o              (valid_o),
    .scheduled_value_o    (scheduled_value_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Scheduled value for one item under the current register settings
  function automatic logic [VALUE_W-1:0] schedule_value(logic [PROG_W-1:0] exp_p,
                                                         logic [PROG_W-1:0] epi_p,
                                                         logic eval);
    longint unsigned prog, p, q, qk, w;
    longint diff, r;
    if (eval) return eval_val;
    prog = use_episode ? epi_p : exp_p;
    if (start_off != 0) begin
      if (prog < start_off) return pre_val;
      if (end_off <= start_off) p = P_ONE;
      else p = ((prog - start_off) << PROGRESS_FRAC_BITS) / (end_off - start_off);
    end else begin
      p = prog;
    end
    if (p > P_ONE) p = P_ONE;
    // ease: w = (1 - (1-p)^k) * p
    if (curve == CURVE_QUAD || curve == CURVE_CUBIC) begin
      q  = P_ONE - p;
      qk = (q * q) >> PROGRESS_FRAC_BITS;
      if (curve == CURVE_CUBIC) qk = (qk * q) >> PROGRESS_FRAC_BITS;
      w  = ((P_ONE - qk) * p) >> PROGRESS_FRAC_BITS;
    end else begin
      w = p;
    end
    diff = longint'(end_val) - longint'(start_val);
    r = longint'(start_val) + ((diff * longint'(w)) >>> PROGRESS_FRAC_BITS);
    if (r > VALUE_MAX) r = VALUE_MAX;
    if (r < VALUE_MIN) r = VALUE_MIN;
    return r[VALUE_W-1:0];
  endfunction

  // Driver: presents queued items, predicts each one as it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (start_i && !busy_o)
        values_due.push_back(schedule_value(experiment_progress_i, episode_progress_i,
                                            is_evaluation_i));
      send_now = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (samples_to_send.size() != 0) begin
        next_sample = samples_to_send.pop_front();
        experiment_progress_i <= next_sample.exp_p;
        episode_progress_i    <= next_sample.epi_p;
        is_evaluation_i       <= next_sample.eval;
        send_now = 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
      end
      start_i <= send_now;
    end
  end

  // Monitor: every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (values_due.size() == 0) begin
        $error("scheduled_value: no item outstanding, expected none, actual %0d",
               $signed(scheduled_value_o));
        err_count++;
      end else begin
        want_value = values_due.pop_front();
        if (scheduled_value_o !== want_value) begin
          $error("scheduled_value: expected %0d, actual %0d",
                 $signed(want_value), $signed(scheduled_value_o));
          err_count++;
        end
      end
    end
  end

  task automatic add_sample(logic [PROG_W-1:0] exp_p, logic [PROG_W-1:0] epi_p,
                            logic eval);
    sample_t s;
    s.exp_p = exp_p;
    s.epi_p = epi_p;
    s.eval  = eval;
    samples_to_send.push_back(s);
  endtask

  // Returns once every item is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (samples_to_send.size() != 0 || start_i || values_due.size() != 0);
  endtask

  task automatic write_reg(isv_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_START_OFFSET:     start_off   = data[PROG_W-1:0];
      REG_END_OFFSET:       end_off     = data[PROG_W-1:0];
      REG_PRE_OFFSET_VALUE: pre_val     = data[VALUE_W-1:0];
      REG_START_VALUE:      start_val   = data[VALUE_W-1:0];
      REG_END_VALUE:        end_val     = data[VALUE_W-1:0];
      REG_EVALUATION_VALUE: eval_val    = data[VALUE_W-1:0];
      REG_CURVE_MODE:       curve       = data[1:0];
      REG_TIME_SOURCE:      use_episode = data[0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_config(logic [PROG_W-1:0] so, logic [PROG_W-1:0] eo, int pre, int sv,
                              int ev, int evv, logic [1:0] crv, logic src);
    write_reg(REG_START_OFFSET, CFG_DATA_W'(so));
    write_reg(REG_END_OFFSET, CFG_DATA_W'(eo));
    write_reg(REG_PRE_OFFSET_VALUE, CFG_DATA_W'(pre));
    write_reg(REG_START_VALUE, CFG_DATA_W'(sv));
    write_reg(REG_END_VALUE, CFG_DATA_W'(ev));
    write_reg(REG_EVALUATION_VALUE, CFG_DATA_W'(evv));
    write_reg(REG_CURVE_MODE, CFG_DATA_W'(crv));
    write_reg(REG_TIME_SOURCE, CFG_DATA_W'(src));
    @(negedge clk_i);
  endtask

  // Value register contents, biased toward the extremes
  function automatic int pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_LO;
      1: return VAL_HI;
      2: return 0;
      3: return $urandom_range(0, 65536);
      default: return int'($urandom);
    endcase
  endfunction

  // Progress values, biased toward the span edges and out-of-range inputs
  function automatic logic [PROG_W-1:0] pick_progress(logic [PROG_W-1:0] so,
                                                      logic [PROG_W-1:0] eo);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PROG_ONE;
      2: return PROG_W'($urandom_range(PROG_ONE + 1, {PROG_W{1'b1}}));
      3: return so;
      4: return so - 1'b1;
      5: return so + 1'b1;
      6: return eo;
      default: return PROG_W'($urandom_range(0, PROG_ONE));
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [PROG_W-1:0] so, eo;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: offset off, linear; includes progress above 1.0 and evaluation
    add_sample(17'd0, 17'h1ffff, 1'b0);
    add_sample(17'd65536, 17'd0, 1'b0);
    add_sample(17'd32768, 17'd21845, 1'b0);
    add_sample(17'h1ffff, 17'd65536, 1'b0);
    add_sample(17'd1, 17'd1, 1'b0);
    add_sample(17'd40000, 17'd12345, 1'b1);
    wait_idle();

    // offset window on episode progress, quadratic ease, full-scale values
    write_config(17'd16384, 17'd49152, VAL_LO, VAL_LO, VAL_HI, VAL_HI, CURVE_QUAD, 1'b1);
    add_sample(17'd0, 17'd16383, 1'b0);
    add_sample(17'd0, 17'd16384, 1'b0);
    add_sample(17'd0, 17'd49152, 1'b0);
    add_sample(17'd0, 17'd65536, 1'b0);
    add_sample(17'h1ffff, 17'h1ffff, 1'b0);
    add_sample(17'd0, 17'd32768, 1'b0);
    add_sample(17'd0, 17'd32768, 1'b1);
    wait_idle();

    // inverted span, cubic ease, falling values
    write_config(17'd16384, 17'd8192, VAL_HI, VAL_HI, VAL_LO, VAL_LO, CURVE_CUBIC, 1'b1);
    add_sample(17'd0, 17'd16384, 1'b0);
    add_sample(17'd0, 17'd20000, 1'b0);
    add_sample(17'd0, 17'd0, 1'b0);
    add_sample(17'd0, 17'd24576, 1'b1);
    wait_idle();

    // empty span on experiment progress
    write_config(17'd40000, 17'd40000, -6554, 100000, -100000, 7, CURVE_LINEAR, 1'b0);
    add_sample(17'd39999, 17'd0, 1'b0);
    add_sample(17'd40000, 17'd0, 1'b0);
    add_sample(17'h1ffff, 17'd0, 1'b0);
    wait_idle();

    // unused curve code on a full ramp
    write_config(17'd0, 17'd65536, 0, VAL_HI, VAL_LO, 0, CURVE_SPARE, 1'b0);
    add_sample(17'd1, 17'd0, 1'b0);
    add_sample(17'd32768, 17'd0, 1'b0);
    add_sample(17'd65535, 17'd0, 1'b0);
    wait_idle();

    // random settings, 25 items each; the last phases run without gaps
    for (int ph = 0; ph < 16; ph++) begin
      case ($urandom_range(0, 7))
        0, 1: so = '0;
        2: so = PROG_ONE;
        default: so = PROG_W'($urandom_range(1, PROG_ONE - 1));
      endcase
      case ($urandom_range(0, 7))
        0: eo = PROG_W'($urandom_range(0, so));
        1: eo = PROG_ONE;
        default: eo = PROG_W'($urandom_range(so, PROG_ONE));
      endcase
      write_config(so, eo, pick_value(), pick_value(), pick_value(), pick_value(),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      gaps_on = (ph < 13) && ($urandom_range(0, 3) != 0);
      repeat (25)
        add_sample(pick_progress(so, eo), pick_progress(so, eo), $urandom_range(0, 7) == 0);
      wait_idle();
    end

    repeat (LATENCY + 4) @(negedge clk_i);
    if (err_count == 0 && values_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #200us;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
